/* design/hssi_pkg.sv */
`timescale 1ns / 1ps

package hssi_pkg;

  localparam logic [14:0] FullTurn    = 15'd23040;
  localparam logic [14:0] HalfTurn    = 15'd11520;
  localparam logic [14:0] QuarterTurn = 15'd5760;

  // radians per 1/64 degree, Q32
  localparam logic [20:0] RadPerUnit = 21'd1171271;

  localparam int unsigned CordicSteps = 16;
  localparam int unsigned IterW       = $clog2(CordicSteps);
  localparam int unsigned AngleW      = 20;

  localparam logic signed [AngleW-1:0] CordicGain = 20'sd39797;
  localparam logic signed [AngleW-1:0] OneQ16     = 20'sd65536;

  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 136;

  typedef enum logic [2:0] {
    CFG_TURN_RATE     = 3'd0,
    CFG_ACCEL_RATE    = 3'd1,
    CFG_START_X       = 3'd2,
    CFG_START_Y       = 3'd3,
    CFG_START_HEADING = 3'd4,
    CFG_START_SPEED   = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic                     start;
    logic signed [AngleW-1:0] angle;
  } cordic_req_t;

  typedef struct packed {
    logic        done;
    logic [16:0] sin_mag;
    logic [16:0] cos_mag;
  } cordic_rsp_t;

  function automatic logic signed [AngleW-1:0] atan_q16(input logic [IterW-1:0] idx);
    logic signed [AngleW-1:0] v;
    case (idx)
      4'd0:    v = 20'sd51472;
      4'd1:    v = 20'sd30386;
      4'd2:    v = 20'sd16055;
      4'd3:    v = 20'sd8150;
      4'd4:    v = 20'sd4091;
      4'd5:    v = 20'sd2047;
      4'd6:    v = 20'sd1024;
      4'd7:    v = 20'sd512;
      4'd8:    v = 20'sd256;
      4'd9:    v = 20'sd128;
      4'd10:   v = 20'sd64;
      4'd11:   v = 20'sd32;
      4'd12:   v = 20'sd16;
      4'd13:   v = 20'sd8;
      4'd14:   v = 20'sd4;
      default: v = 20'sd2;
    endcase
    return v;
  endfunction

  function automatic logic [16:0] clamp_q16(input logic signed [AngleW-1:0] v);
    logic [16:0] r;
    if (v[AngleW-1]) begin
      r = '0;
    end else if (v > OneQ16) begin
      r = 17'h10000;
    end else begin
      r = v[16:0];
    end
    return r;
  endfunction

endpackage

/* design/hssi_mul.sv */
`timescale 1ns / 1ps

module hssi_mul (
  input  logic        clk_i,
  input  logic [20:0] a_i,
  input  logic [16:0] b_i,
  output logic [37:0] p_o
);

  logic [37:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= 38'(a_i) * 38'(b_i);
  end

  assign p_o = p_q;

endmodule

/* design/hssi_cordic.sv */
`timescale 1ns / 1ps

module hssi_cordic (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  hssi_pkg::cordic_req_t req_i,
  output hssi_pkg::cordic_rsp_t rsp_o
);

  logic signed [hssi_pkg::AngleW-1:0] x_q, x_d, y_q, y_d, z_q, z_d, dx, dy;
  logic [hssi_pkg::IterW-1:0]         it_q, it_d;
  logic                               busy_q, busy_d, done_q, done_d;

  always_comb begin
    dx     = y_q >>> it_q;
    dy     = x_q >>> it_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    it_d   = it_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      x_d    = hssi_pkg::CordicGain;
      y_d    = '0;
      z_d    = req_i.angle;
      it_d   = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!z_q[hssi_pkg::AngleW-1]) begin
        x_d = x_q - dx;
        y_d = y_q + dy;
        z_d = z_q - hssi_pkg::atan_q16(it_q);
      end else begin
        x_d = x_q + dx;
        y_d = y_q - dy;
        z_d = z_q + hssi_pkg::atan_q16(it_q);
      end
      it_d = it_q + 1'b1;
      if (it_q == hssi_pkg::IterW'(hssi_pkg::CordicSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      it_q   <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      it_q   <= it_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign rsp_o.done    = done_q;
  assign rsp_o.sin_mag = hssi_pkg::clamp_q16(y_q);
  assign rsp_o.cos_mag = hssi_pkg::clamp_q16(x_q);

endmodule

/* design/heading_speed_slew_integrator.sv */
`timescale 1ns / 1ps

// Heading and speed slew integrator. Each input transfer carries a time step and the
// commanded heading and speed; the block turns the heading toward the target the short
// way round, slews the speed, forms the velocity from a 16-iteration CORDIC and adds it
// to the wrapping 16.16 position. A new item is taken only after the result of the last one
// has gone into the output register, and that handover waits while the output side stalls;
// the work runs through the 16 CORDIC iterations and the single shared 21x17 multiplier,
// used seven times per item. The output register holds a result while the next item is
// worked on. Configuration writes are taken only while no item is being worked on; writing
// a start register also loads the matching position, heading or speed at once.
module heading_speed_slew_integrator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // step_time[9:0], target_heading[24:10], target_speed[40:25]
  input  logic [hssi_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // pos_x[31:0], pos_y[63:32], cur_heading[78:64], cur_speed[94:79],
  // vel_x[111:95], vel_y[128:112]
  output logic [hssi_pkg::OutDataW-1:0] m_axis_tdata,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [2:0]                    cfg_index_i,
  input  logic [31:0]                   cfg_data_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_TURN, S_ACCEL, S_SPEED, S_ANGLE, S_CORDIC,
    S_VX, S_VY, S_PX, S_PY, S_POSY, S_DONE
  } state_e;

  state_e state_q;

  logic [15:0] turn_rate_q, accel_rate_q;
  logic [14:0] heading_q, heading_d;
  logic [15:0] speed_q, speed_d;
  logic [31:0] x_q, y_q, pos_d;

  logic [9:0]  dt_q;
  logic [14:0] tgt_h_q, tgt_h_in;
  logic [15:0] tgt_s_q;
  logic [1:0]  quad_q, quad_d;
  logic signed [16:0] vx_q, vy_q, vel_d;

  logic        out_valid_q;
  logic [31:0] out_x_q, out_y_q;
  logic [14:0] out_h_q;
  logic [15:0] out_s_q;
  logic [16:0] out_vx_q, out_vy_q;

  logic [20:0] mul_a;
  logic [16:0] mul_b;
  logic [37:0] mul_p;

  hssi_pkg::cordic_req_t cordic_req;
  hssi_pkg::cordic_rsp_t cordic_rsp;

  logic        in_xfer, cfg_xfer, out_free;
  logic [25:0] step_sum;
  logic [15:0] step;
  logic [15:0] hdiff;
  logic [14:0] hd, hm, hmove;
  logic [15:0] hsum;
  logic [14:0] rem;
  logic [16:0] s_val, c_val, vmag_src;
  logic        s_neg, c_neg, vneg;
  logic [31:0] vprod;
  logic [15:0] vm;
  logic [37:0] angle_sum;
  logic [16:0] vel_abs_src;
  logic signed [16:0] vel_sel;
  logic [23:0] pdist;
  logic [25:0] psum;
  logic [14:0] cfg_heading;

  hssi_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  hssi_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (cordic_req),
    .rsp_o  (cordic_rsp)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = (state_q == S_IDLE);
  assign cfg_xfer      = cfg_valid_i && cfg_ready_o;
  assign out_free      = !out_valid_q || m_axis_tready;

  assign tgt_h_in = (s_axis_tdata[24:10] >= hssi_pkg::FullTurn) ?
                    s_axis_tdata[24:10] - hssi_pkg::FullTurn : s_axis_tdata[24:10];
  assign cfg_heading = (cfg_data_i[14:0] >= hssi_pkg::FullTurn) ?
                       cfg_data_i[14:0] - hssi_pkg::FullTurn : cfg_data_i[14:0];

  // rounded rate * dt step, shared by heading and speed
  assign step_sum = mul_p[25:0] + 26'd512;
  assign step     = step_sum[25:10];

  // heading slew
  always_comb begin
    hdiff = {1'b0, tgt_h_q} - {1'b0, heading_q};
    hd    = hdiff[15] ? hdiff[14:0] + hssi_pkg::FullTurn : hdiff[14:0];
    hm    = hssi_pkg::FullTurn - hd;
    hmove = '0;
    hsum  = {1'b0, heading_q};
    heading_d = heading_q;
    if (hd != '0) begin
      if (hd <= hssi_pkg::HalfTurn) begin
        hmove = (step < {1'b0, hd}) ? step[14:0] : hd;
        hsum  = {1'b0, heading_q} + {1'b0, hmove};
        heading_d = (hsum >= {1'b0, hssi_pkg::FullTurn}) ?
                    hsum[14:0] - hssi_pkg::FullTurn : hsum[14:0];
      end else begin
        hmove = (step < {1'b0, hm}) ? step[14:0] : hm;
        hsum  = {1'b0, heading_q} - {1'b0, hmove};
        heading_d = hsum[15] ? hsum[14:0] + hssi_pkg::FullTurn : hsum[14:0];
      end
    end
  end

  // speed slew
  always_comb begin
    speed_d = speed_q;
    if (speed_q < tgt_s_q) begin
      speed_d = ((tgt_s_q - speed_q) > step) ? speed_q + step : tgt_s_q;
    end else if (speed_q > tgt_s_q) begin
      speed_d = ((speed_q - tgt_s_q) > step) ? speed_q - step : tgt_s_q;
    end
  end

  // quadrant split of the new heading
  always_comb begin
    if (heading_q >= 15'd17280) begin
      quad_d = 2'd3;
      rem    = heading_q - 15'd17280;
    end else if (heading_q >= hssi_pkg::HalfTurn) begin
      quad_d = 2'd2;
      rem    = heading_q - hssi_pkg::HalfTurn;
    end else if (heading_q >= hssi_pkg::QuarterTurn) begin
      quad_d = 2'd1;
      rem    = heading_q - hssi_pkg::QuarterTurn;
    end else begin
      quad_d = 2'd0;
      rem    = heading_q;
    end
  end

  always_comb begin
    case (quad_q)
      2'd0: begin
        s_val = cordic_rsp.sin_mag; s_neg = 1'b0;
        c_val = cordic_rsp.cos_mag; c_neg = 1'b0;
      end
      2'd1: begin
        s_val = cordic_rsp.cos_mag; s_neg = 1'b0;
        c_val = cordic_rsp.sin_mag; c_neg = 1'b1;
      end
      2'd2: begin
        s_val = cordic_rsp.sin_mag; s_neg = 1'b1;
        c_val = cordic_rsp.cos_mag; c_neg = 1'b1;
      end
      default: begin
        s_val = cordic_rsp.cos_mag; s_neg = 1'b1;
        c_val = cordic_rsp.sin_mag; c_neg = 1'b0;
      end
    endcase
  end

  assign angle_sum = mul_p + 38'd32768;
  assign cordic_req.start = (state_q == S_ANGLE);
  assign cordic_req.angle = $signed(angle_sum[35:16]);

  // velocity from speed * |trig|
  assign vneg  = (state_q == S_VY) ? s_neg : !c_neg;
  assign vprod = mul_p[31:0] + 32'd32768;
  assign vm    = vprod[31:16];
  assign vel_d = vneg ? -$signed({1'b0, vm}) : $signed({1'b0, vm});

  // position step from |vel| * dt
  assign vel_sel     = (state_q == S_PY) ? vx_q : vy_q;
  assign psum        = mul_p[25:0] + 26'd2;
  assign pdist       = psum[25:2];
  assign pos_d       = vel_sel[16] ? ((state_q == S_PY) ? x_q : y_q) - 32'(pdist)
                                   : ((state_q == S_PY) ? x_q : y_q) + 32'(pdist);

  assign vel_abs_src = (state_q == S_PX) ? vx_q : vy_q;
  assign vmag_src    = vel_abs_src[16] ? 17'(-$signed(vel_abs_src)) : vel_abs_src;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_TURN: begin
        mul_a = 21'(turn_rate_q);
        mul_b = 17'(dt_q);
      end
      S_ACCEL: begin
        mul_a = 21'(accel_rate_q);
        mul_b = 17'(dt_q);
      end
      S_SPEED: begin
        mul_a = hssi_pkg::RadPerUnit;
        mul_b = 17'(rem);
      end
      S_VX: begin
        mul_a = 21'(speed_q);
        mul_b = s_val;
      end
      S_VY: begin
        mul_a = 21'(speed_q);
        mul_b = c_val;
      end
      S_PX, S_PY: begin
        mul_a = 21'(vmag_src[15:0]);
        mul_b = 17'(dt_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      turn_rate_q  <= 16'd192;
      accel_rate_q <= 16'd1280;
      heading_q    <= '0;
      speed_q      <= '0;
      x_q          <= '0;
      y_q          <= '0;
    end else begin
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE:   if (in_xfer) state_q <= S_TURN;
        S_TURN:   state_q <= S_ACCEL;
        S_ACCEL: begin
          heading_q <= heading_d;
          state_q   <= S_SPEED;
        end
        S_SPEED: begin
          speed_q <= speed_d;
          state_q <= S_ANGLE;
        end
        S_ANGLE:  state_q <= S_CORDIC;
        S_CORDIC: if (cordic_rsp.done) state_q <= S_VX;
        S_VX:     state_q <= S_VY;
        S_VY:     state_q <= S_PX;
        S_PX:     state_q <= S_PY;
        S_PY: begin
          x_q     <= pos_d;
          state_q <= S_POSY;
        end
        S_POSY: begin
          y_q     <= pos_d;
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default:  state_q <= S_IDLE;
      endcase
      if (cfg_xfer) begin
        unique case (hssi_pkg::cfg_idx_e'(cfg_index_i))
          hssi_pkg::CFG_TURN_RATE:     turn_rate_q  <= cfg_data_i[15:0];
          hssi_pkg::CFG_ACCEL_RATE:    accel_rate_q <= cfg_data_i[15:0];
          hssi_pkg::CFG_START_X:       x_q          <= cfg_data_i;
          hssi_pkg::CFG_START_Y:       y_q          <= cfg_data_i;
          hssi_pkg::CFG_START_HEADING: heading_q    <= cfg_heading;
          hssi_pkg::CFG_START_SPEED:   speed_q      <= cfg_data_i[15:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      dt_q    <= s_axis_tdata[9:0];
      tgt_h_q <= tgt_h_in;
      tgt_s_q <= s_axis_tdata[40:25];
    end
    if (state_q == S_SPEED) begin
      quad_q <= quad_d;
    end
    if (state_q == S_VY) begin
      vx_q <= vel_d;
    end
    if (state_q == S_PX) begin
      vy_q <= vel_d;
    end
    if (state_q == S_DONE && out_free) begin
      out_x_q  <= x_q;
      out_y_q  <= y_q;
      out_h_q  <= heading_q;
      out_s_q  <= speed_q;
      out_vx_q <= vx_q;
      out_vy_q <= vy_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_vy_q, out_vx_q, out_s_q, out_h_q, out_y_q, out_x_q};

endmodule

/* design/hssi_checker.sv */
`timescale 1ns / 1ps

module hssi_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [hssi_pkg::OutDataW-1:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while busy");

  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without work");

  a_heading_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[78:64] < hssi_pkg::FullTurn)
    else $error("heading out of range");

  a_vel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[111:95] != 17'h10000) &&
                      (m_axis_tdata[128:112] != 17'h10000))
    else $error("velocity out of range");

endmodule

bind heading_speed_slew_integrator hssi_checker u_hssi_checker (.*);
